// File: rtl/core/vdn_pkg.sv
// Shared widths, stage counts and meta type for the 2D direction normalizer.
package vdn_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int Q_W        = 16;
    localparam int DIV_STEPS  = Q_W;

    localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};

    typedef struct packed {
        logic             zero;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } meta_t;

endpackage

// File: rtl/core/vector2d_direction_normalize.sv
// Pipelined 2D direction normalizer: difference, squared length, root, divide.
//
//  channel  | signals                                         | role
//  ---------+-------------------------------------------------+---------------------
//  in       | valid, ready, first_x/y, second_x/y             | point pair
//  out      | out_valid, out_ready, unit_x/y, zero_length     | Q1.15 unit direction
//
// One transfer per cycle while the output is not stalled. The pipeline is the input,
// square and sum registers, one root bit per stage in the square root chain, one divider
// load stage, one quotient bit per stage in the two dividers and the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module vector2d_direction_normalize
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic signed [31:0]  first_x,
    input  logic signed [31:0]  first_y,
    input  logic signed [31:0]  second_x,
    input  logic signed [31:0]  second_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  unit_x,
    output logic signed [15:0]  unit_y,
    output logic                zero_length
);

    logic en;

    logic                         s0_valid_reg;
    vdn_pkg::meta_t               s0_meta_reg;
    logic                         s1_valid_reg;
    vdn_pkg::meta_t               s1_meta_reg;
    logic [vdn_pkg::PROD_W-1:0]   s1_sx_reg;
    logic [vdn_pkg::PROD_W-1:0]   s1_sy_reg;

    logic                         sq_valid_reg [0:vdn_pkg::SQRT_STEPS];
    vdn_pkg::meta_t               sq_meta_reg  [0:vdn_pkg::SQRT_STEPS];
    logic [vdn_pkg::SQ_W-1:0]     sq_s_reg     [0:vdn_pkg::SQRT_STEPS];
    logic [vdn_pkg::REM_W-1:0]    sq_rem_reg   [0:vdn_pkg::SQRT_STEPS];
    logic [vdn_pkg::ROOT_W-1:0]   sq_root_reg  [0:vdn_pkg::SQRT_STEPS];

    logic                         dv_valid_reg [0:vdn_pkg::DIV_STEPS];
    vdn_pkg::meta_t               dv_meta_reg  [0:vdn_pkg::DIV_STEPS];
    logic [vdn_pkg::DIV_W-1:0]    dv_len_reg   [0:vdn_pkg::DIV_STEPS];
    logic [vdn_pkg::DIV_W-1:0]    dv_rx_reg    [0:vdn_pkg::DIV_STEPS];
    logic [vdn_pkg::DIV_W-1:0]    dv_ry_reg    [0:vdn_pkg::DIV_STEPS];
    logic [vdn_pkg::Q_W-1:0]      dv_qx_reg    [0:vdn_pkg::DIV_STEPS];
    logic [vdn_pkg::Q_W-1:0]      dv_qy_reg    [0:vdn_pkg::DIV_STEPS];

    logic                         out_valid_reg;
    logic [vdn_pkg::Q_W-1:0]      unit_x_reg;
    logic [vdn_pkg::Q_W-1:0]      unit_y_reg;
    logic                         zero_reg;

    logic signed [vdn_pkg::DIFF_W-1:0] dx;
    logic signed [vdn_pkg::DIFF_W-1:0] dy;
    logic [vdn_pkg::DIFF_W-1:0]        ax_full;
    logic [vdn_pkg::DIFF_W-1:0]        ay_full;
    vdn_pkg::meta_t                    s0_meta_next;
    logic [vdn_pkg::SQ_W-1:0]          s2_sum;
    logic [vdn_pkg::Q_W-1:0]           unit_x_next;
    logic [vdn_pkg::Q_W-1:0]           unit_y_next;

    assign en    = !out_valid_reg || out_ready;
    assign ready = en;

    always_comb
    begin
        dx      = $signed({second_x[31], second_x}) - $signed({first_x[31], first_x});
        dy      = $signed({second_y[31], second_y}) - $signed({first_y[31], first_y});
        ax_full = dx[vdn_pkg::DIFF_W-1] ? vdn_pkg::DIFF_W'(-dx) : vdn_pkg::DIFF_W'(dx);
        ay_full = dy[vdn_pkg::DIFF_W-1] ? vdn_pkg::DIFF_W'(-dy) : vdn_pkg::DIFF_W'(dy);
        s0_meta_next.zero  = (dx == '0) && (dy == '0);
        s0_meta_next.neg_x = dx[vdn_pkg::DIFF_W-1];
        s0_meta_next.neg_y = dy[vdn_pkg::DIFF_W-1];
        s0_meta_next.mag_x = ax_full[vdn_pkg::MAG_W-1:0];
        s0_meta_next.mag_y = ay_full[vdn_pkg::MAG_W-1:0];
        s2_sum = {2'b00, s1_sx_reg} + {2'b00, s1_sy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= valid;
            s1_valid_reg    <= s0_valid_reg;
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_meta_reg    <= s0_meta_next;
            s1_meta_reg    <= s0_meta_reg;
            s1_sx_reg      <= s0_meta_reg.mag_x * s0_meta_reg.mag_x;
            s1_sy_reg      <= s0_meta_reg.mag_y * s0_meta_reg.mag_y;
            sq_meta_reg[0] <= s1_meta_reg;
            sq_s_reg[0]    <= s2_sum;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < vdn_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int PAIR_LO = 2 * (vdn_pkg::SQRT_STEPS - 1 - k);
        logic [vdn_pkg::REM_W-1:0]  rem_sh;
        logic [vdn_pkg::ROOT_W-1:0] root_sh;
        logic [vdn_pkg::REM_W-1:0]  trial;
        logic                       ge;

        always_comb
        begin
            rem_sh  = {sq_rem_reg[k][vdn_pkg::REM_W-3:0], sq_s_reg[k][PAIR_LO+1 -: 2]};
            root_sh = {sq_root_reg[k][vdn_pkg::ROOT_W-2:0], 1'b0};
            trial   = vdn_pkg::REM_W'({root_sh, 1'b1});
            ge      = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (en)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_meta_reg[k+1] <= sq_meta_reg[k];
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[k+1] <= root_sh | vdn_pkg::ROOT_W'(ge);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= sq_valid_reg[vdn_pkg::SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_meta_reg[0] <= sq_meta_reg[vdn_pkg::SQRT_STEPS];
            dv_len_reg[0]  <= {1'b0, sq_root_reg[vdn_pkg::SQRT_STEPS]};
            dv_rx_reg[0]   <= vdn_pkg::DIV_W'(sq_meta_reg[vdn_pkg::SQRT_STEPS].mag_x);
            dv_ry_reg[0]   <= vdn_pkg::DIV_W'(sq_meta_reg[vdn_pkg::SQRT_STEPS].mag_y);
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < vdn_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [vdn_pkg::DIV_W-1:0] rx_sh;
        logic [vdn_pkg::DIV_W-1:0] ry_sh;
        logic                      gex;
        logic                      gey;

        always_comb
        begin
            if (j == 0)
            begin
                rx_sh = dv_rx_reg[j];
                ry_sh = dv_ry_reg[j];
            end
            else
            begin
                rx_sh = {dv_rx_reg[j][vdn_pkg::DIV_W-2:0], 1'b0};
                ry_sh = {dv_ry_reg[j][vdn_pkg::DIV_W-2:0], 1'b0};
            end
            gex = rx_sh >= dv_len_reg[j];
            gey = ry_sh >= dv_len_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (en)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_meta_reg[j+1] <= dv_meta_reg[j];
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_rx_reg[j+1]   <= gex ? rx_sh - dv_len_reg[j] : rx_sh;
                dv_ry_reg[j+1]   <= gey ? ry_sh - dv_len_reg[j] : ry_sh;
                dv_qx_reg[j+1]   <= {dv_qx_reg[j][vdn_pkg::Q_W-2:0], gex};
                dv_qy_reg[j+1]   <= {dv_qy_reg[j][vdn_pkg::Q_W-2:0], gey};
            end
        end
    end

    always_comb
    begin
        if (dv_meta_reg[vdn_pkg::DIV_STEPS].zero)
        begin
            unit_x_next = '0;
            unit_y_next = '0;
        end
        else
        begin
            if (dv_meta_reg[vdn_pkg::DIV_STEPS].neg_x)
                unit_x_next = -dv_qx_reg[vdn_pkg::DIV_STEPS];
            else if (dv_qx_reg[vdn_pkg::DIV_STEPS][vdn_pkg::Q_W-1])
                unit_x_next = vdn_pkg::Q_POS_MAX;
            else
                unit_x_next = dv_qx_reg[vdn_pkg::DIV_STEPS];
            if (dv_meta_reg[vdn_pkg::DIV_STEPS].neg_y)
                unit_y_next = -dv_qy_reg[vdn_pkg::DIV_STEPS];
            else if (dv_qy_reg[vdn_pkg::DIV_STEPS][vdn_pkg::Q_W-1])
                unit_y_next = vdn_pkg::Q_POS_MAX;
            else
                unit_y_next = dv_qy_reg[vdn_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid_reg[vdn_pkg::DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_x_reg <= unit_x_next;
            unit_y_reg <= unit_y_next;
            zero_reg   <= dv_meta_reg[vdn_pkg::DIV_STEPS].zero;
        end
    end

    assign out_valid   = out_valid_reg;
    assign unit_x      = $signed(unit_x_reg);
    assign unit_y      = $signed(unit_y_reg);
    assign zero_length = zero_reg;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> unit_x == '0 && unit_y == '0)
        else $error("zero length result carries nonzero direction");

    a_nonzero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_length |-> unit_x != '0 || unit_y != '0)
        else $error("nonzero length gives null direction");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        ready == (!out_valid || out_ready))
        else $error("input ready disagrees with output stall");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(zero_length))
        else $error("stalled result lost");

endmodule

// File: tb/tb_vector2d_direction_normalize.sv
// Testbench for the 2D direction normalizer: random and directed point pairs, scoreboard check.
`timescale 1ns / 100ps

class direction_scoreboard;
    logic signed [15:0] exp_x_q[$];
    logic signed [15:0] exp_y_q[$];
    logic               exp_zero_q[$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    static function logic [32:0] root_of(logic [65:0] s);
        logic [35:0] rem;
        logic [32:0] root;
        logic [35:0] trial;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 36'(s[2*i +: 2]);
            root = root << 1;
            trial = (36'(root) << 1) | 36'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    static function logic signed [15:0] scale(logic signed [32:0] d, logic [32:0] len);
        logic [32:0] m;
        logic [63:0] q;
        m = d[32] ? -d : d;
        q = {16'd0, m, 15'd0} / {31'd0, len};
        if (!d[32])
            return (q > 64'd32767) ? 16'sd32767 : q[15:0];
        return -q[15:0];
    endfunction

    function void note_points(logic signed [31:0] fx, logic signed [31:0] fy,
                              logic signed [31:0] sx, logic signed [31:0] sy);
        logic signed [32:0] dx, dy;
        logic [32:0] ax, ay, len;
        logic [65:0] sq;
        dx = 33'(sx) - 33'(fx);
        dy = 33'(sy) - 33'(fy);
        ax = dx[32] ? -dx : dx;
        ay = dy[32] ? -dy : dy;
        sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        if (dx == 0 && dy == 0) begin
            exp_x_q.push_back(16'sd0);
            exp_y_q.push_back(16'sd0);
            exp_zero_q.push_back(1'b1);
        end else begin
            len = root_of(sq);
            exp_x_q.push_back(scale(dx, len));
            exp_y_q.push_back(scale(dy, len));
            exp_zero_q.push_back(1'b0);
        end
    endfunction

    function void check_unit(logic signed [15:0] ux, logic signed [15:0] uy, logic z);
        logic signed [15:0] ex, ey;
        logic ez;
        if (exp_x_q.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d zero=%0b", $time, ux, uy, z);
            errors++;
            return;
        end
        ex = exp_x_q.pop_front();
        ey = exp_y_q.pop_front();
        ez = exp_zero_q.pop_front();
        if (ux !== ex) begin
            $display("%0t: unit_x expected %0d actual %0d", $time, ex, ux);
            errors++;
        end
        if (uy !== ey) begin
            $display("%0t: unit_y expected %0d actual %0d", $time, ey, uy);
            errors++;
        end
        if (z !== ez) begin
            $display("%0t: zero_length expected %0b actual %0b", $time, ez, z);
            errors++;
        end
    endfunction

    function int pending();
        return exp_x_q.size();
    endfunction
endclass

module tb_vector2d_direction_normalize;

    localparam int LATENCY = 54;
    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               valid = 1'b0;
    logic               ready;
    logic signed [31:0] first_x = '0;
    logic signed [31:0] first_y = '0;
    logic signed [31:0] second_x = '0;
    logic signed [31:0] second_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic               zero_length;

    direction_scoreboard sb = new();
    bit  calm = 1'b0;
    int  idle_cycles = 0;

    vector2d_direction_normalize dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (valid && ready)
            sb.note_points(first_x, first_y, second_x, second_y);
        if (out_valid && out_ready)
            sb.check_unit(unit_x, unit_y, zero_length);
        if ((valid && ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n)
            out_ready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_vector2d_direction_normalize failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_points(logic [31:0] fx, logic [31:0] fy,
                               logic [31:0] sx, logic [31:0] sy);
        while (!calm && $urandom_range(99) < 7) begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid    <= 1'b1;
        first_x  <= fx;
        first_y  <= fy;
        second_x <= sx;
        second_y <= sy;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [31:0] fx, fy;
        fx = pick_coord();
        fy = pick_coord();
        case ($urandom_range(9))
            0: send_points(fx, fy, fx, fy);
            1: send_points(fx, fy, fx, pick_coord());
            2: send_points(fx, fy, pick_coord(), fy);
            3: send_points(fx, fy, fx + 32'($urandom_range(3)), fy - 32'($urandom_range(3)));
            default: send_points(fx, fy, pick_coord(), pick_coord());
        endcase
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_points(32'd0, 32'd0, 32'd0, 32'd0);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_points(32'd0, 32'd0, 32'd1, 32'd0);
        send_points(32'd0, 32'd0, 32'd0, 32'd1);
        send_points(32'd1, 32'd0, 32'd0, 32'd0);
        send_points(32'd0, 32'd1, 32'd0, 32'd0);
        send_points(32'd0, 32'd0, 32'd1, 32'd1);
        send_points(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_points(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_points(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_points(32'd0, 32'd0, 32'd3, 32'd4);
        send_points(32'd0, 32'd0, 32'hFFFF_FFFD, 32'd4);
        send_points(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_points(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0);
        send_points(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        for (int i = 0; i < 640; i++) begin
            calm = (i >= 300 && i < 400);
            send_random();
        end
        valid <= 1'b0;
        calm = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_vector2d_direction_normalize passed");
        else
            $display("tb_vector2d_direction_normalize failed");
        $finish;
    end

endmodule
